[rtl/swlru_pkg.sv]
// package: payload types, mode and status codes for the size weighted lru cache
`default_nettype none
package swlru_pkg;
   localparam int unsigned DefaultEntries = 16;
   localparam logic [47:0] CapacityReset = 48'd1048576;

   typedef enum logic [1:0] {
      MODE_LOOKUP = 2'd0,
      MODE_ADD    = 2'd1,
      MODE_RENEW  = 2'd2,
      MODE_EMPTY  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_ABSENT  = 2'd1,
      STATUS_TOO_BIG = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      KIND_EVICT  = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] object_key;
      logic [31:0] object_size;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [31:0] reported_key;
      logic [31:0] reported_size;
      logic        hit;
      logic [1:0]  status;
      logic [47:0] bytes_left;
      logic        last;
   } rsp_type;
endpackage
`default_nettype wire

[rtl/swlru_scan.sv]
// scan unit: walks the table one entry a cycle for key match, free slot and oldest entry
`default_nettype none
module swlru_scan #(
   parameter int unsigned ENTRIES = swlru_pkg::DefaultEntries
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [31:0]                match_key,
   input  wire logic [31:0]                use_count,
   input  wire logic                       ent_valid,
   input  wire logic [31:0]                ent_key,
   input  wire logic [31:0]                ent_stamp,
   output logic [$clog2(ENTRIES)-1:0]      addr,
   output logic                            busy,
   output logic                            key_found,
   output logic [$clog2(ENTRIES)-1:0]      key_idx,
   output logic                            free_found,
   output logic [$clog2(ENTRIES)-1:0]      free_idx,
   output logic                            old_found,
   output logic [$clog2(ENTRIES)-1:0]      old_idx
);
   localparam int unsigned IW = $clog2(ENTRIES);
   localparam logic [IW-1:0] LastIdx = IW'(ENTRIES - 1);

   logic [IW-1:0] addr_ff, addr_in;
   logic busy_ff, busy_in;
   logic kf_ff, kf_in, ff_ff, ff_in, of_ff, of_in;
   logic [IW-1:0] ki_ff, ki_in, fi_ff, fi_in, oi_ff, oi_in;
   logic [31:0] age_ff, age_in, age;

   assign age = use_count - ent_stamp;

   always_comb begin
      addr_in = addr_ff; busy_in = busy_ff;
      kf_in = kf_ff; ki_in = ki_ff; ff_in = ff_ff; fi_in = fi_ff;
      of_in = of_ff; oi_in = oi_ff; age_in = age_ff;
      if (start) begin
         addr_in = '0; busy_in = 1'b1;
         kf_in = 1'b0; ff_in = 1'b0; of_in = 1'b0;
      end else if (busy_ff) begin
         if (ent_valid) begin
            if (!kf_ff && ent_key == match_key) begin
               kf_in = 1'b1; ki_in = addr_ff;
            end
            if (!of_ff || age > age_ff) begin
               of_in = 1'b1; oi_in = addr_ff; age_in = age;
            end
         end else if (!ff_ff) begin
            ff_in = 1'b1; fi_in = addr_ff;
         end
         if (addr_ff == LastIdx) busy_in = 1'b0;
         else addr_in = addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; addr_ff <= '0;
         kf_ff <= 1'b0; ff_ff <= 1'b0; of_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; addr_ff <= addr_in;
         kf_ff <= kf_in; ff_ff <= ff_in; of_ff <= of_in;
      end
      ki_ff <= ki_in; fi_ff <= fi_in; oi_ff <= oi_in; age_ff <= age_in;
   end

   assign addr = addr_ff;
   assign busy = busy_ff;
   assign key_found = kf_ff;  assign key_idx = ki_ff;
   assign free_found = ff_ff; assign free_idx = fi_ff;
   assign old_found = of_ff;  assign old_idx = oi_ff;
endmodule
`default_nettype wire

[rtl/size_weighted_lru_cache.sv]
// top level: size weighted lru cache with sequential table scans
//
// requests enter on req_valid/req_stall, results leave on rsp_valid/rsp_stall.
// each request gives zero or more eviction reports followed by one status
// result with rsp_payload.last set. the table is walked by one scan unit,
// one entry per cycle, and each scan ends in a decision step. a lookup,
// renew of an absent key, reject or empty takes one scan before the status
// result. an add or renew of a present key takes two scans plus a write,
// and each eviction adds one report and a rescan.
// the block takes one request at a time; req_stall is high while busy and
// while a csr write is offered.
// csr_valid/csr_ready writes byte_capacity, clears the table and restores the
// byte budget; writes are taken only when no request is in flight.
// synchronous reset clears the table, the use counter and sets the capacity
// to its default. while rsp_stall is high the result is held and the
// sequencer waits before it loads the next one.
`default_nettype none
module size_weighted_lru_cache #(
   parameter int unsigned ENTRIES = swlru_pkg::DefaultEntries
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire swlru_pkg::req_type req_payload,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output swlru_pkg::rsp_type      rsp_payload,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [47:0]        csr_data
);
   import swlru_pkg::*;
   localparam int unsigned IW = $clog2(ENTRIES);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCAN  = 6'b000010,
      ST_DEC   = 6'b000100,
      ST_EVICT = 6'b001000,
      ST_WRITE = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [31:0] key_mem [ENTRIES];
   logic [31:0] size_mem [ENTRIES];
   logic [31:0] stamp_mem [ENTRIES];
   logic [47:0] cap_ff, cap_in, rem_ff, rem_in;
   logic [31:0] use_ff, use_in;
   req_type req_ff, req_in;
   logic [31:0] size_ff, size_in, old_ff, old_in;
   logic hit_ff, hit_in, first_ff, first_in;
   status_type stat_ff, stat_in;
   rsp_type rsp_ff, rsp_in;
   logic rspv_ff, rspv_in;
   logic [31:0] rd_key, rd_stamp, ev_size;

   logic scan_start, s_busy, s_kf, s_ff, s_of;
   logic [IW-1:0] s_addr, s_ki, s_fi, s_oi;

   assign rd_key   = key_mem[s_addr];
   assign rd_stamp = stamp_mem[s_addr];
   assign ev_size  = size_mem[s_oi];

   swlru_scan #(.ENTRIES(ENTRIES)) u_scan (
      .clock, .reset, .start(scan_start), .match_key(req_ff.object_key),
      .use_count(use_ff), .ent_valid(valid_ff[s_addr]), .ent_key(rd_key),
      .ent_stamp(rd_stamp), .addr(s_addr), .busy(s_busy),
      .key_found(s_kf), .key_idx(s_ki), .free_found(s_ff), .free_idx(s_fi),
      .old_found(s_of), .old_idx(s_oi)
   );

   // a csr write takes the idle cycle, so the request waits
   assign req_stall = (state_ff != ST_IDLE) || csr_valid;
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rspv_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in = state_ff; valid_in = valid_ff; cap_in = cap_ff; rem_in = rem_ff;
      use_in = use_ff; req_in = req_ff; size_in = size_ff; old_in = old_ff;
      hit_in = hit_ff; first_in = first_ff; stat_in = stat_ff;
      rsp_in = rsp_ff; rspv_in = rspv_ff; scan_start = 1'b0;
      if (rspv_ff && !rsp_stall) rspv_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               cap_in = csr_data; rem_in = csr_data; valid_in = '0;
            end else if (req_valid) begin
               req_in = req_payload; scan_start = 1'b1;
               first_in = 1'b1; state_in = ST_SCAN;
            end
         end
         ST_SCAN: if (!s_busy) state_in = ST_DEC;
         ST_DEC: begin
            // first scan: classify the request
            if (first_ff) begin
               first_in = 1'b0;
               hit_in = s_kf;
               old_in = s_kf ? size_mem[s_ki] : 32'd0;
               stat_in = STATUS_OK;
               size_in = (mode_type'(req_ff.mode) == MODE_RENEW) ? size_mem[s_ki]
                                                                 : req_ff.object_size;
               case (mode_type'(req_ff.mode))
                  MODE_LOOKUP: state_in = ST_OUT;
                  MODE_EMPTY: begin
                     valid_in = '0; rem_in = cap_ff;
                     state_in = ST_OUT;
                  end
                  MODE_RENEW: begin
                     if (!s_kf) begin
                        stat_in = STATUS_ABSENT;
                        state_in = ST_OUT;
                     end else if ({16'd0, size_mem[s_ki]} > cap_ff) begin
                        stat_in = STATUS_TOO_BIG; state_in = ST_OUT;
                     end else begin
                        valid_in[s_ki] = 1'b0; rem_in = rem_ff + {16'd0, size_mem[s_ki]};
                        scan_start = 1'b1; state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     if ({16'd0, req_ff.object_size} > cap_ff) begin
                        stat_in = STATUS_TOO_BIG; state_in = ST_OUT;
                     end else begin
                        if (s_kf) begin
                           valid_in[s_ki] = 1'b0;
                           rem_in = rem_ff + {16'd0, size_mem[s_ki]};
                        end
                        scan_start = 1'b1; state_in = ST_SCAN;
                     end
                  end
               endcase
            end else if (s_of && (!s_ff || {16'd0, size_ff} > rem_ff)) begin
               state_in = ST_EVICT;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_EVICT: if (!rspv_ff || !rsp_stall) begin
            valid_in[s_oi] = 1'b0;
            rem_in = rem_ff + {16'd0, ev_size};
            rsp_in = '{result_kind: KIND_EVICT, reported_key: key_mem[s_oi],
                       reported_size: ev_size, hit: 1'b0, status: STATUS_OK,
                       bytes_left: rem_ff + {16'd0, ev_size}, last: 1'b0};
            rspv_in = 1'b1; scan_start = 1'b1; state_in = ST_SCAN;
         end
         ST_WRITE: begin
            // budget saturates at zero if still short
            rem_in = ({16'd0, size_ff} > rem_ff) ? 48'd0 : rem_ff - {16'd0, size_ff};
            if (s_ff) valid_in[s_fi] = 1'b1;
            use_in = use_ff + 32'd1;
            state_in = ST_OUT;
         end
         ST_OUT: if (!rspv_ff || !rsp_stall) begin
            rsp_in = '{result_kind: KIND_STATUS, reported_key: req_ff.object_key,
                       reported_size: old_ff, hit: hit_ff, status: stat_ff,
                       bytes_left: rem_ff, last: 1'b1};
            rspv_in = 1'b1; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; valid_ff <= '0; cap_ff <= CapacityReset;
         rem_ff <= CapacityReset; use_ff <= '0; rspv_ff <= 1'b0; first_ff <= 1'b0;
      end else begin
         state_ff <= state_in; valid_ff <= valid_in; cap_ff <= cap_in;
         rem_ff <= rem_in; use_ff <= use_in; rspv_ff <= rspv_in; first_ff <= first_in;
      end
      req_ff <= req_in; size_ff <= size_in; old_ff <= old_in; hit_ff <= hit_in;
      stat_ff <= stat_in; rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_WRITE && s_ff) begin
         key_mem[s_fi] <= req_ff.object_key;
         size_mem[s_fi] <= size_ff;
         stamp_mem[s_fi] <= use_ff;
      end
   end

   a_busy_no_csr: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !csr_ready) else $error("csr ready while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("result changed under stall");
   a_use: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_WRITE) |=> $stable(use_ff)) else $error("use counter moved");
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
endmodule
`default_nettype wire

[test/tb_top.sv]
// testbench for the size weighted lru cache: random and directed requests, predicted results
`timescale 1ns / 1ps
`default_nettype none

class lru_scoreboard;
   localparam int Slots = 16;
   bit          slot_used [Slots];
   logic [31:0] slot_key [Slots];
   logic [31:0] slot_size [Slots];
   logic [31:0] slot_stamp [Slots];
   logic [31:0] use_count;
   logic [47:0] capacity;
   logic [47:0] budget;
   swlru_pkg::rsp_type pending [$];
   int errors;

   function void reset_state();
      capacity = swlru_pkg::CapacityReset;
      use_count = '0;
      errors = 0;
      pending.delete();
      clear_table();
   endfunction

   function void clear_table();
      for (int i = 0; i < Slots; i++) slot_used[i] = 0;
      budget = capacity;
   endfunction

   function void set_capacity(logic [47:0] value);
      capacity = value;
      clear_table();
   endfunction

   function int lookup_slot(logic [31:0] key);
      for (int i = 0; i < Slots; i++)
         if (slot_used[i] && slot_key[i] == key) return i;
      return -1;
   endfunction

   function int free_slot();
      for (int i = 0; i < Slots; i++)
         if (!slot_used[i]) return i;
      return -1;
   endfunction

   function int oldest_slot();
      int best;
      logic [31:0] best_age, age;
      best = -1;
      best_age = '0;
      for (int i = 0; i < Slots; i++)
         if (slot_used[i]) begin
            age = use_count - slot_stamp[i];
            if (best < 0 || age > best_age) begin
               best = i;
               best_age = age;
            end
         end
      return best;
   endfunction

   function void push_result(bit kind, logic [31:0] key, logic [31:0] size, bit hit,
                             swlru_pkg::status_type st, bit last);
      swlru_pkg::rsp_type r;
      r.result_kind = kind;
      r.reported_key = key;
      r.reported_size = size;
      r.hit = hit;
      r.status = st;
      r.bytes_left = budget;
      r.last = last;
      pending.push_back(r);
   endfunction

   function void evict_oldest();
      int v;
      v = oldest_slot();
      if (v < 0) return;
      slot_used[v] = 0;
      budget = budget + slot_size[v];
      push_result(swlru_pkg::KIND_EVICT, slot_key[v], slot_size[v], 0,
                  swlru_pkg::STATUS_OK, 0);
   endfunction

   function void store_object(logic [31:0] key, logic [31:0] size, int idx, bit hit,
                              logic [31:0] old_size);
      int s;
      if ({16'd0, size} > capacity) begin
         push_result(swlru_pkg::KIND_STATUS, key, old_size, hit,
                     swlru_pkg::STATUS_TOO_BIG, 1);
         return;
      end
      if (idx >= 0) begin
         slot_used[idx] = 0;
         budget = budget + slot_size[idx];
      end
      if (free_slot() < 0) evict_oldest();
      while ({16'd0, size} > budget && oldest_slot() >= 0) evict_oldest();
      if ({16'd0, size} > budget) budget = '0;
      else budget = budget - size;
      s = free_slot();
      if (s >= 0) begin
         slot_used[s] = 1;
         slot_key[s] = key;
         slot_size[s] = size;
         slot_stamp[s] = use_count;
      end
      use_count = use_count + 1;
      push_result(swlru_pkg::KIND_STATUS, key, old_size, hit, swlru_pkg::STATUS_OK, 1);
   endfunction

   function void note_request(swlru_pkg::req_type q);
      int idx;
      bit hit;
      logic [31:0] old_size;
      idx = lookup_slot(q.object_key);
      hit = idx >= 0;
      old_size = hit ? slot_size[idx] : '0;
      case (swlru_pkg::mode_type'(q.mode))
         swlru_pkg::MODE_ADD: store_object(q.object_key, q.object_size, idx, hit, old_size);
         swlru_pkg::MODE_RENEW: begin
            if (!hit)
               push_result(swlru_pkg::KIND_STATUS, q.object_key, '0, 0,
                           swlru_pkg::STATUS_ABSENT, 1);
            else store_object(q.object_key, slot_size[idx], idx, hit, old_size);
         end
         swlru_pkg::MODE_EMPTY: begin
            clear_table();
            push_result(swlru_pkg::KIND_STATUS, q.object_key, old_size, hit,
                        swlru_pkg::STATUS_OK, 1);
         end
         default: push_result(swlru_pkg::KIND_STATUS, q.object_key, old_size, hit,
                              swlru_pkg::STATUS_OK, 1);
      endcase
   endfunction

   function void check_result(swlru_pkg::rsp_type got);
      swlru_pkg::rsp_type e;
      if (pending.size() == 0) begin
         $error("unexpected result key=%h", got.reported_key);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (got.result_kind !== e.result_kind) begin
         $error("result_kind exp %h got %h", e.result_kind, got.result_kind); errors++;
      end
      if (got.reported_key !== e.reported_key) begin
         $error("reported_key exp %h got %h", e.reported_key, got.reported_key); errors++;
      end
      if (got.reported_size !== e.reported_size) begin
         $error("reported_size exp %h got %h", e.reported_size, got.reported_size); errors++;
      end
      if (got.hit !== e.hit) begin
         $error("hit exp %h got %h", e.hit, got.hit); errors++;
      end
      if (got.status !== e.status) begin
         $error("status exp %h got %h", e.status, got.status); errors++;
      end
      if (got.bytes_left !== e.bytes_left) begin
         $error("bytes_left exp %h got %h", e.bytes_left, got.bytes_left); errors++;
      end
      if (got.last !== e.last) begin
         $error("last exp %h got %h", e.last, got.last); errors++;
      end
   endfunction
endclass

module tb_top;
   import swlru_pkg::*;

   localparam int IdleLimit = 20000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   rsp_type rsp_payload;
   logic csr_valid = 0;
   logic csr_ready;
   logic [47:0] csr_data = '0;

   lru_scoreboard board = new();
   bit hold_rsp = 0;
   bit stall_pattern = 0;
   int idle_cycles = 0;
   logic [31:0] key_pool [8];

   size_weighted_lru_cache DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) board.note_request(req_payload);
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_payload);
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver stall pattern, overridden by a long hold-off
   always @(negedge clock) begin
      if (hold_rsp) rsp_stall <= 1;
      else if (!stall_pattern) rsp_stall <= 0;
      else rsp_stall <= ($urandom_range(0, 3) == 0);
   end

   task automatic send_request(mode_type m, logic [31:0] key, logic [31:0] size);
      req_payload <= '{mode: m, object_key: key, object_size: size};
      req_valid <= 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic pause_sender();
      req_valid <= 0;
      repeat ($urandom_range(1, 12)) @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic write_capacity(logic [47:0] value);
      wait_drained();
      csr_data <= value;
      csr_valid <= 1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.set_capacity(value);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic random_phase(int count, int small_sizes);
      int burst;
      logic [31:0] key, size;
      mode_type m;
      burst = 0;
      for (int n = 0; n < count; n++) begin
         if (burst == 0) begin
            pause_sender();
            burst = $urandom_range(1, 10);
         end
         burst--;
         case ($urandom_range(0, 9))
            0, 1: m = MODE_LOOKUP;
            2, 3, 4, 5: m = MODE_ADD;
            6, 7, 8: m = MODE_RENEW;
            default: m = ($urandom_range(0, 3) == 0) ? MODE_EMPTY : MODE_ADD;
         endcase
         key = ($urandom_range(0, 4) == 0) ? $urandom() : key_pool[$urandom_range(0, 7)];
         case ($urandom_range(0, 5))
            0: size = $urandom();
            1: size = '1;
            default: size = $urandom_range(0, small_sizes);
         endcase
         send_request(m, key, size);
      end
   endtask

   initial begin
      for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
      key_pool[0] = '0;
      key_pool[1] = '1;
      board.reset_state();
      repeat (2) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: extremes, every mode, replacement, oversize, absent renew
      send_request(MODE_LOOKUP, 32'h0, 32'h0);
      send_request(MODE_RENEW, 32'hffff_ffff, 32'h5);
      send_request(MODE_ADD, 32'h0, 32'h0);
      send_request(MODE_ADD, 32'hffff_ffff, 32'hffff_ffff);
      send_request(MODE_ADD, 32'h1234, 32'd1048576);
      send_request(MODE_LOOKUP, 32'h1234, 32'h0);
      send_request(MODE_ADD, 32'h55aa, 32'd100);
      send_request(MODE_ADD, 32'h55aa, 32'd7);
      send_request(MODE_RENEW, 32'h0, 32'hffff_ffff);
      send_request(MODE_LOOKUP, 32'h0, 32'h0);
      send_request(MODE_EMPTY, 32'h55aa, 32'h0);
      send_request(MODE_LOOKUP, 32'h55aa, 32'h0);
      // full table: more keys than slots, oldest goes first
      for (int i = 0; i < 18; i++) send_request(MODE_ADD, 32'h100 + i, 32'd1);
      send_request(MODE_RENEW, 32'h102, 32'h0);

      write_capacity('1);
      random_phase(30, 100000);
      write_capacity('0);
      random_phase(15, 3);
      write_capacity(48'd1000);
      stall_pattern = 1;
      random_phase(40, 300);
      // long receiver hold-off while the sender keeps offering
      fork
         begin
            hold_rsp = 1;
            repeat (400) @(negedge clock);
            hold_rsp = 0;
         end
         random_phase(6, 300);
      join
      wait_drained();
      write_capacity(48'd1 << 32);
      random_phase(25, 32'h2000_0000);
      write_capacity(48'd200);
      stall_pattern = 0;
      random_phase(25, 60);

      wait_drained();
      if (board.errors == 0 && board.pending.size() == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule
`default_nettype wire
